[hdl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque unit.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 8;
  localparam int DEPTH_DEF = 128;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_POP_TAIL  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

  // controller to datapath
  typedef struct packed {
    logic exec;   // apply the accepted operation
    logic rd;     // read front and back entries
    logic load;   // load the result register
  } bdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } bdq_sts_t;

endpackage

[hdl/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept and execute, read the ends, load the result.
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bdq_sts_t sts,
  output bdq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // hold until the result register can take the new result
        cmd.load = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/bdq_datapath.sv]
// ----------------------------------------------------------------------------
// bdq_datapath
// Circular buffer store, head and count registers, result register.
// ----------------------------------------------------------------------------
module bdq_datapath
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bdq_cmd_t                   cmd,
  output bdq_sts_t                   sts,
  input  logic [OP_W-1:0]            in_opcode,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_front_value,
  output logic signed [DATA_W-1:0]   out_back_value,
  output logic [COUNT_W-1:0]         out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  status_t         status_r, status_nxt;
  logic [DATA_W-1:0] rd_front_r, rd_back_r;

  logic            wr_en;
  logic [AW-1:0]   wr_slot;
  logic            full, empty;
  logic [AW-1:0]   head_dec, head_inc, tail_slot, back_slot;
  logic [AW:0]     tail_sum, back_sum;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r;
  logic [DATA_W-1:0]        out_front_r, out_back_r;
  logic [COUNT_W-1:0]       out_count_r;

  assign full  = (cnt_r == DEPTH_C);
  assign empty = (cnt_r == '0);

  // modulo DEPTH steps; every sum stays below twice DEPTH
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;

  assign tail_sum  = {1'b0, head_r} + (AW + 1)'(cnt_r);
  assign tail_slot = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);

  assign back_sum  = tail_sum - 1'b1;
  assign back_slot = empty ? head_r :
                     (back_sum >= DEPTH_X) ? AW'(back_sum - DEPTH_X) : AW'(back_sum);

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    wr_slot    = tail_slot;
    unique case (opcode_t'(in_opcode))
      OP_PUSH_HEAD: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          head_nxt = head_dec;
          wr_slot  = head_dec;
          wr_en    = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      OP_PUSH_TAIL: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_POP_HEAD: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      OP_POP_TAIL: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) status_r <= status_nxt;
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_slot] <= in_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_front_r <= mem[head_r];
      rd_back_r  <= mem[back_slot];
    end
  end

  // result register
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= status_r;
      out_front_r  <= empty ? EMPTY_WORD : rd_front_r;
      out_back_r   <= empty ? EMPTY_WORD : rd_back_r;
      out_count_r  <= COUNT_W'(cnt_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_count       = out_count_r;

endmodule

[hdl/bounded_deque_unit.sv]
// ----------------------------------------------------------------------------
// bounded_deque_unit
// Double-ended queue of signed words in a circular buffer of DEPTH entries.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | dir
//  ---------+-----------------------------------------------+-----
//  input    | in_valid/in_ready, in_opcode, in_value        | in
//  result   | out_valid/out_ready, out_status,              | out
//           | out_front_value, out_back_value, out_count    |
//
//  An operation runs in steps: accept and update head/count/store,
//  read both ends from the store (registered read), load the result register.
//  The next item is accepted while the previous result waits in the result
//  register.
//  A stalled result register holds the sequencer in its load step.
//  Reset clears head and count; the store is not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_unit
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_opcode,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_front_value,
  output logic signed [DATA_W-1:0]   out_back_value,
  output logic [COUNT_W-1:0]         out_count
);

  bdq_cmd_t cmd;
  bdq_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count)
  );

endmodule

[hdl/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the bounded deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker
  import bdq_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [STATUS_W-1:0]        out_status,
  input logic signed [DATA_W-1:0]   out_front_value,
  input logic signed [DATA_W-1:0]   out_back_value,
  input logic [COUNT_W-1:0]         out_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_front_value) && $stable(out_back_value) && $stable(out_count))
    else $error("result changed while stalled");

  // one operation in flight: no transfer in the cycle after one
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an operation is in flight");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == '0 |-> out_front_value == EMPTY_WORD &&
      out_back_value == EMPTY_WORD)
    else $error("empty deque shows words other than all ones");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDERFLOW |-> out_count == '0)
    else $error("underflow reported on a non-empty deque");

  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == COUNT_W'(1) |-> out_front_value == out_back_value)
    else $error("front and back differ with one word held");

endmodule

bind bounded_deque_unit bdq_checker u_bdq_checker (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_deque_unit. A directed table covers the
// empty and wrap-around cases, then random runs fill the deque to overflow,
// drain it to underflow and mix operations in between. Every result transfer
// is compared with a row's own result or a software deque fed at each input.
// ----------------------------------------------------------------------------
module testbench;
  import bdq_pkg::*;

  localparam int DQ_DEPTH    = DEPTH_DEF;
  localparam int IDX_W       = $clog2(DQ_DEPTH);
  localparam int HOLD_CYCLES = 400;
  localparam int N_ROWS      = 17;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   front;
    logic [DATA_W-1:0]   back;
    logic [COUNT_W-1:0]  count;
  } deque_res_t;

  typedef struct packed {
    opcode_t            op;
    logic [DATA_W-1:0]  word;
    logic               typed;   // expected result given in the row
    deque_res_t         want;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           in_opcode = OP_PUSH_HEAD;
  logic signed [DATA_W-1:0]  in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic signed [DATA_W-1:0]  out_front_value;
  logic signed [DATA_W-1:0]  out_back_value;
  logic [COUNT_W-1:0]        out_count;

  // travel with the payload so the acceptance monitor knows the row's intent
  logic                      item_typed = 1'b0;
  deque_res_t                item_want = '0;

  bounded_deque_unit #(.DEPTH(DQ_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // software deque
  logic [DATA_W-1:0]   dq_words [DQ_DEPTH];
  logic [IDX_W-1:0]    dq_head = '0;
  logic [COUNT_W-1:0]  dq_held = '0;

  deque_res_t pending_results [$];
  int         mismatch_cnt = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  int         hold_seq = 0;
  int         gen_level = 0;   // fill level as seen by the generator

  dir_row_t dir_rows [N_ROWS];

  function automatic deque_res_t deque_apply(opcode_t op, logic [DATA_W-1:0] word);
    deque_res_t r;
    r.status = ST_OK;
    case (op)
      OP_PUSH_HEAD: begin
        if (dq_held >= DQ_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          dq_head = IDX_W'((dq_head + DQ_DEPTH - 1) % DQ_DEPTH);
          dq_words[dq_head] = word;
          dq_held++;
        end
      end
      OP_PUSH_TAIL: begin
        if (dq_held >= DQ_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          dq_words[IDX_W'((dq_head + dq_held) % DQ_DEPTH)] = word;
          dq_held++;
        end
      end
      OP_POP_HEAD: begin
        if (dq_held == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          dq_head = IDX_W'((dq_head + 1) % DQ_DEPTH);
          dq_held--;
        end
      end
      default: begin
        if (dq_held == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          dq_held--;
        end
      end
    endcase
    if (dq_held == 0) begin
      r.front = EMPTY_WORD;
      r.back  = EMPTY_WORD;
    end else begin
      r.front = dq_words[dq_head];
      r.back  = dq_words[IDX_W'((dq_head + dq_held - 1) % DQ_DEPTH)];
    end
    r.count = dq_held;
    return r;
  endfunction

  // input transfers: update the software deque, queue the expectation
  always @(posedge clk) begin : accept_mon
    deque_res_t predicted;
    if (rst_n && in_valid && in_ready) begin
      predicted = deque_apply(opcode_t'(in_opcode), in_value);
      if (item_typed) begin
        pending_results = {pending_results, item_want};
      end else begin
        pending_results = {pending_results, predicted};
      end
    end
  end

  // result transfers: compare with the oldest expectation
  always @(posedge clk) begin : result_mon
    deque_res_t want;
    deque_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_t'(out_status);
      got.front  = out_front_value;
      got.back   = out_back_value;
      got.count  = out_count;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: st=%0d front=%h back=%h cnt=%0d",
                   got.status, got.front, got.back, got.count);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.status != want.status || got.front != want.front ||
            got.back != want.back || got.count != want.count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"mismatch: exp st=%0d front=%h back=%h cnt=%0d, ",
                      "got st=%0d front=%h back=%h cnt=%0d"},
                     want.status, want.front, want.back, want.count,
                     got.status, got.front, got.back, got.count);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin : rcv_drive
    int hold_left;
    int seen_seq;
    if (hold_seq != seen_seq) begin
      seen_seq  = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic send_op(opcode_t op, logic [DATA_W-1:0] word, logic typed,
                         deque_res_t want);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_value   <= word;
    item_typed <= typed;
    item_want  <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (op == OP_PUSH_HEAD || op == OP_PUSH_TAIL) begin
      if (gen_level < DQ_DEPTH) gen_level++;
    end else if (gen_level > 0) begin
      gen_level--;
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_rand(bit push);
    opcode_t op;
    if (push) op = opcode_t'($urandom_range(0, 1));
    else      op = opcode_t'($urandom_range(2, 3));
    send_op(op, rand_word(), 1'b0, '0);
  endtask

  // segments: fill past full, drain past empty, or a random mix
  task automatic run_random(int n, bit fill_first);
    int done;
    int kind;
    int len;
    int k;
    done = 0;
    while (done < n) begin
      kind = (fill_first && done == 0) ? 0 : $urandom_range(0, 9);
      if (kind <= 1) begin
        len = DQ_DEPTH - gen_level + $urandom_range(1, 3);
        for (k = 0; k < len; k++) send_rand(1'b1);
      end else if (kind <= 3) begin
        len = gen_level + $urandom_range(1, 3);
        for (k = 0; k < len; k++) send_rand(1'b0);
      end else begin
        len = $urandom_range(10, 40);
        for (k = 0; k < len; k++) send_rand($urandom_range(0, 1));
      end
      done += len;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin : stim
    int i;
    dir_rows = '{
      // pops on the empty deque, value ignored
      '{OP_POP_HEAD,  32'h1234_5678, 1'b1, '{ST_UNDERFLOW, EMPTY_WORD, EMPTY_WORD, 8'd0}},
      '{OP_POP_TAIL,  32'h0000_0000, 1'b1, '{ST_UNDERFLOW, EMPTY_WORD, EMPTY_WORD, 8'd0}},
      // push at the head from slot 0 wraps to the last slot
      '{OP_PUSH_HEAD, 32'h7fff_ffff, 1'b1, '{ST_OK, 32'h7fff_ffff, 32'h7fff_ffff, 8'd1}},
      '{OP_PUSH_TAIL, 32'h8000_0000, 1'b1, '{ST_OK, 32'h7fff_ffff, 32'h8000_0000, 8'd2}},
      '{OP_PUSH_HEAD, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0000, 32'h8000_0000, 8'd3}},
      '{OP_PUSH_TAIL, 32'hffff_ffff, 1'b1, '{ST_OK, 32'h0000_0000, 32'hffff_ffff, 8'd4}},
      '{OP_POP_TAIL,  32'haaaa_aaaa, 1'b1, '{ST_OK, 32'h0000_0000, 32'h8000_0000, 8'd3}},
      '{OP_POP_HEAD,  32'h5555_5555, 1'b1, '{ST_OK, 32'h7fff_ffff, 32'h8000_0000, 8'd2}},
      '{OP_POP_HEAD,  32'hffff_ffff, 1'b1, '{ST_OK, 32'h8000_0000, 32'h8000_0000, 8'd1}},
      '{OP_POP_TAIL,  32'h0000_0001, 1'b1, '{ST_OK, EMPTY_WORD, EMPTY_WORD, 8'd0}},
      '{OP_POP_TAIL,  32'h8000_0000, 1'b1, '{ST_UNDERFLOW, EMPTY_WORD, EMPTY_WORD, 8'd0}},
      // emptied deque keeps its head; next push starts there
      '{OP_PUSH_TAIL, 32'h0000_0001, 1'b1, '{ST_OK, 32'h0000_0001, 32'h0000_0001, 8'd1}},
      '{OP_PUSH_HEAD, 32'hdead_beef, 1'b0, '0},
      '{OP_PUSH_TAIL, 32'h0bad_f00d, 1'b0, '0},
      '{OP_POP_HEAD,  32'h0f0f_0f0f, 1'b0, '0},
      '{OP_POP_TAIL,  32'hf0f0_f0f0, 1'b0, '0},
      '{OP_POP_TAIL,  32'h7fff_ffff, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 35;
    rcv_idle_pct = 85;
    for (i = 0; i < N_ROWS; i++)
      send_op(dir_rows[i].op, dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    run_random(500, 1'b1);
    drain_results();

    snd_idle_pct = 85;
    rcv_idle_pct = 35;
    run_random(250, 1'b0);
    // long receiver hold-off while items keep coming
    hold_seq <= hold_seq + 1;
    run_random(250, 1'b0);
    drain_results();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(500, 1'b0);
    drain_results();

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
